// ===== hw/rtl/softened_gravity_acceleration_top_macros.svh =====
// Assertion macros for the softened gravity acceleration block.
// Used by the top level only; no other dependencies.
`ifndef SOFTENED_GRAVITY_ACCELERATION_TOP_MACROS_SVH
`define SOFTENED_GRAVITY_ACCELERATION_TOP_MACROS_SVH

// Condition a must be followed later by c; argument n sets the delay.
`define SGA_ASSERT_AFTER(label, clk, rst_n, a, n, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##(n) (c)) \
    else $error("sga: delayed property failed");

// Condition a implies c in the same cycle.
`define SGA_ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sga: implication failed");

`endif

// ===== hw/rtl/sga_pkg.sv =====
// Shared types and constants of the softened gravity acceleration block.
// No dependencies.
package sga_pkg;

  localparam int unsigned FrontStages = 4;
  localparam int unsigned SqrtSteps   = 48;
  localparam int unsigned DivSteps    = 32;
  localparam int unsigned DivStages   = DivSteps + 4;
  localparam int unsigned Latency     = FrontStages + SqrtSteps + DivStages;

  localparam int unsigned SW   = 66;   // sum of squares
  localparam int unsigned PmW  = 97;   // G*m*|d|
  localparam int unsigned SqW  = 98;   // square root remainder
  localparam int unsigned DW   = 114;  // denominator S*R
  localparam int unsigned NW   = 128;  // numerator G*m*|d|*2^31
  localparam int unsigned RemW = 146;  // divider remainder

  localparam logic [31:0] GravReset = 32'd65536;
  localparam logic [31:0] SoftReset = 32'd655;

  typedef enum logic [7:0] {
    CfgGrav = 8'd0,
    CfgSoft = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic [31:0]        other_mass;
  } operands_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic               range_flag;
  } result_t;

  typedef struct packed {
    logic [31:0] grav;
    logic [31:0] eps;
  } cfg_t;

  typedef struct packed {
    logic [PmW-1:0] pm_x;
    logic [PmW-1:0] pm_y;
    logic           neg_x;
    logic           neg_y;
    logic           zero;
    logic [SW-1:0]  s;
  } side_t;

endpackage

// ===== hw/rtl/sga_front.sv =====
// Front stages: separation, squares, softened sum and G*m*|d| products.
// Depends on sga_pkg.
module sga_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  sga_pkg::operands_t operands_i,
  input  sga_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output sga_pkg::side_t     side_o
);

  logic [sga_pkg::FrontStages-1:0] v_q;

  logic signed [32:0] dx, dy;
  logic [32:0] s1_ax_d, s1_ay_d, s1_ax_q, s1_ay_q;
  logic s1_nx_q, s1_ny_q;
  logic [31:0] s1_m_q;

  logic [65:0] s2_sqx_q, s2_sqy_q;
  logic [63:0] s2_sqe_q, s2_gm_q;
  logic [32:0] s2_ax_q, s2_ay_q;
  logic s2_nx_q, s2_ny_q;

  logic [sga_pkg::SW-1:0] s3_s_q;
  logic s3_zero_q, s3_nx_q, s3_ny_q;
  logic [64:0] s3_plx_q, s3_phx_q, s3_ply_q, s3_phy_q;

  sga_pkg::side_t s4_q;

  assign dx = {operands_i.other_x[31], operands_i.other_x}
            - {operands_i.own_x[31], operands_i.own_x};
  assign dy = {operands_i.other_y[31], operands_i.other_y}
            - {operands_i.own_y[31], operands_i.own_y};
  assign s1_ax_d = dx[32] ? 33'(-dx) : 33'(dx);
  assign s1_ay_d = dy[32] ? 33'(-dy) : 33'(dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[sga_pkg::FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ax_q <= s1_ax_d;
    s1_ay_q <= s1_ay_d;
    s1_nx_q <= dx[32];
    s1_ny_q <= dy[32];
    s1_m_q  <= operands_i.other_mass;

    s2_sqx_q <= 66'(s1_ax_q) * 66'(s1_ax_q);
    s2_sqy_q <= 66'(s1_ay_q) * 66'(s1_ay_q);
    s2_sqe_q <= 64'(cfg_i.eps) * 64'(cfg_i.eps);
    s2_gm_q  <= 64'(cfg_i.grav) * 64'(s1_m_q);
    s2_ax_q  <= s1_ax_q;
    s2_ay_q  <= s1_ay_q;
    s2_nx_q  <= s1_nx_q;
    s2_ny_q  <= s1_ny_q;

    s3_s_q    <= s2_sqx_q + s2_sqy_q + 66'(s2_sqe_q);
    s3_zero_q <= (s2_sqx_q == '0) && (s2_sqy_q == '0) && (s2_sqe_q == '0);
    s3_plx_q  <= 65'(s2_gm_q[31:0]) * 65'(s2_ax_q);
    s3_phx_q  <= 65'(s2_gm_q[63:32]) * 65'(s2_ax_q);
    s3_ply_q  <= 65'(s2_gm_q[31:0]) * 65'(s2_ay_q);
    s3_phy_q  <= 65'(s2_gm_q[63:32]) * 65'(s2_ay_q);
    s3_nx_q   <= s2_nx_q;
    s3_ny_q   <= s2_ny_q;

    s4_q.pm_x  <= sga_pkg::PmW'(s3_plx_q) + {s3_phx_q, 32'b0};
    s4_q.pm_y  <= sga_pkg::PmW'(s3_ply_q) + {s3_phy_q, 32'b0};
    s4_q.neg_x <= s3_nx_q;
    s4_q.neg_y <= s3_ny_q;
    s4_q.zero  <= s3_zero_q;
    s4_q.s     <= s3_s_q;
  end

  assign valid_o = v_q[sga_pkg::FrontStages-1];
  assign side_o  = s4_q;

endmodule

// ===== hw/rtl/sga_sqrt.sv =====
// Pipelined bit-serial square root of S*2^30, one root bit per stage.
// Depends on sga_pkg.
module sga_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sga_pkg::side_t side_i,
  output logic           valid_o,
  output logic [47:0]    root_o,
  output sga_pkg::side_t side_o
);

  localparam int unsigned N = sga_pkg::SqrtSteps;

  logic [N-1:0]            v_q;
  logic [sga_pkg::SqW-1:0] rem_q  [N];
  logic [47:0]             root_q [N];
  sga_pkg::side_t          side_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int unsigned B = N - 1 - k;
    logic [sga_pkg::SqW-1:0] rem_in, trial;
    logic [47:0]             root_in;
    sga_pkg::side_t          side_in;
    logic                    ge;

    if (k == 0) begin : g_first
      assign rem_in  = {2'b0, side_i.s, 30'b0};
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Adding bit B to root r grows the square by 2*r*2^B + 2^(2B).
    assign trial = (sga_pkg::SqW'(root_in) << (B + 1))
                 + (sga_pkg::SqW'(1) << (2 * B));
    assign ge = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? rem_in - trial : rem_in;
      root_q[k] <= ge ? (root_in | (48'(1) << B)) : root_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ===== hw/rtl/sga_div.sv =====
// Denominator product, overflow test, 32-stage divider for both components
// and saturation. Depends on sga_pkg.
module sga_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [47:0]      root_i,
  input  sga_pkg::side_t   side_i,
  output logic             valid_o,
  output sga_pkg::result_t result_o
);

  localparam int unsigned N = sga_pkg::DivSteps;

  logic [sga_pkg::DivStages-1:0] v_q;

  // Partial products of S (three 22-bit chunks) and R (two 24-bit chunks).
  logic [45:0]    p_pp_q [3][2];
  sga_pkg::side_t p_side_q;

  logic [sga_pkg::DW-1:0] d_den_d, d_den_q;
  logic [sga_pkg::NW-1:0] d_num_q [2];
  logic [1:0]             d_neg_q;
  logic                   d_zero_q;

  logic [sga_pkg::RemW-1:0] o_rem_q [2];
  logic [1:0]               o_ovf_q, o_neg_q;
  logic [sga_pkg::DW-1:0]   o_den_q;
  logic                     o_zero_q;

  logic [sga_pkg::RemW-1:0] rem_q [N][2];
  logic [31:0]              quo_q [N][2];
  logic [1:0]               ovf_q [N];
  logic [1:0]               neg_q [N];
  logic [sga_pkg::DW-1:0]   den_q [N];
  logic                     zero_q [N];

  sga_pkg::result_t res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[sga_pkg::DivStages-2:0], valid_i};
    end
  end

  always_comb begin
    d_den_d = '0;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 2; i++) begin
        d_den_d = d_den_d + (sga_pkg::DW'(p_pp_q[j][i]) << (22 * j + 24 * i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 2; i++) begin
        p_pp_q[j][i] <= 46'(side_i.s[22*j +: 22]) * 46'(root_i[24*i +: 24]);
      end
    end
    p_side_q <= side_i;

    d_den_q    <= d_den_d;
    d_num_q[0] <= {p_side_q.pm_x, 31'b0};
    d_num_q[1] <= {p_side_q.pm_y, 31'b0};
    d_neg_q    <= {p_side_q.neg_y, p_side_q.neg_x};
    d_zero_q   <= p_side_q.zero;

    // A quotient of 2^32 or more saturates whatever its low bits are.
    for (int l = 0; l < 2; l++) begin
      o_rem_q[l] <= sga_pkg::RemW'(d_num_q[l]);
      o_ovf_q[l] <= sga_pkg::RemW'(d_num_q[l]) >= {d_den_q, 32'b0};
    end
    o_neg_q  <= d_neg_q;
    o_den_q  <= d_den_q;
    o_zero_q <= d_zero_q;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int unsigned B = N - 1 - k;
    logic [sga_pkg::RemW-1:0] rem_in [2];
    logic [31:0]              quo_in [2];
    logic [1:0]               ovf_in, neg_in;
    logic [sga_pkg::DW-1:0]   den_in;
    logic                     zero_in;
    logic [sga_pkg::RemW-1:0] dsh;

    if (k == 0) begin : g_first
      assign rem_in  = o_rem_q;
      assign quo_in  = '{32'b0, 32'b0};
      assign ovf_in  = o_ovf_q;
      assign neg_in  = o_neg_q;
      assign den_in  = o_den_q;
      assign zero_in = o_zero_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign ovf_in  = ovf_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign den_in  = den_q[k-1];
      assign zero_in = zero_q[k-1];
    end

    assign dsh = sga_pkg::RemW'(den_in) << B;

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_q[k][l] <= rem_in[l] - dsh;
          quo_q[k][l] <= quo_in[l] | (32'(1) << B);
        end else begin
          rem_q[k][l] <= rem_in[l];
          quo_q[k][l] <= quo_in[l];
        end
      end
      ovf_q[k]  <= ovf_in;
      neg_q[k]  <= neg_in;
      den_q[k]  <= den_in;
      zero_q[k] <= zero_in;
    end
  end

  always_comb begin
    logic [31:0] limit, mag;
    logic [31:0] val [2];
    logic        flag;
    flag = 1'b0;
    for (int l = 0; l < 2; l++) begin
      limit = neg_q[N-1][l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag   = quo_q[N-1][l];
      if (ovf_q[N-1][l] || (mag > limit)) begin
        mag  = limit;
        flag = 1'b1;
      end
      val[l] = neg_q[N-1][l] ? 32'(-mag) : mag;
    end
    if (zero_q[N-1]) begin
      res_d.accel_x    = '0;
      res_d.accel_y    = '0;
      res_d.range_flag = 1'b1;
    end else begin
      res_d.accel_x    = val[0];
      res_d.accel_y    = val[1];
      res_d.range_flag = flag;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = v_q[sga_pkg::DivStages-1];
  assign result_o = res_q;

endmodule

// ===== hw/rtl/softened_gravity_acceleration_top.sv =====
// Top level of the softened gravity acceleration block: configuration
// registers and the front, square root and divider pipelines.
// Depends on sga_pkg, sga_front, sga_sqrt, sga_div and the macros header.
//
//   channel   direction  handshake                     word
//   operands  in         start_i, busy_o               operands_i
//   results   out        done_o (one-cycle strobe)     result_o
//   config    in         cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
//
// One body pair is taken every cycle; busy_o never rises.
// Each result passes 4 front stages, the 48-stage square root, product,
// denominator and overflow stages, the 32-stage divider and a final register.
// Reset clears the stage valid bits and loads G = 1.0 and eps = 655/65536.
// There is no stall: the receiver takes every strobed word.
`include "softened_gravity_acceleration_top_macros.svh"

module softened_gravity_acceleration_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  sga_pkg::operands_t operands_i,
  output logic               done_o,
  output sga_pkg::result_t   result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  sga_pkg::cfg_t  cfg_q;
  logic           accept;
  logic           f_valid, s_valid;
  sga_pkg::side_t f_side, s_side;
  logic [47:0]    s_root;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grav <= sga_pkg::GravReset;
      cfg_q.eps  <= sga_pkg::SoftReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sga_pkg::CfgGrav: cfg_q.grav <= cfg_data_i;
        sga_pkg::CfgSoft: cfg_q.eps  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sga_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .operands_i (operands_i),
    .cfg_i      (cfg_q),
    .valid_o    (f_valid),
    .side_o     (f_side)
  );

  sga_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  sga_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_valid),
    .root_i   (s_root),
    .side_i   (s_side),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  `SGA_ASSERT_AFTER(a_latency, clk_i, rst_ni, accept, sga_pkg::Latency, done_o)
  `SGA_ASSERT_IMPLIES(a_no_phantom, clk_i, rst_ni, done_o, $past(accept, sga_pkg::Latency))

endmodule
